// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands for the positional list engine, clocked on aclk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every edge outside reset
`define PLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// consequence that must hold at the edge after the antecedent
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// command, status and cell control codes for the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

    // beat field widths
    localparam int OP_W      = 3;
    localparam int POS_W     = 8;
    localparam int ITEM_W    = 64;
    localparam int DATA_W    = 64;
    localparam int FIDX_W    = 6;
    localparam int ECNT_W    = 7;
    localparam int STAT_W    = 3;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 80;

    // commands
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_SWAP   = 3'd4,
        OP_READ   = 3'd5,
        OP_FIND   = 3'd6,
        OP_CLEAR  = 3'd7
    } opcode_t;

    // result status
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADIDX   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // what every cell does with its entry in the apply cycle
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_WRITE  = 2'd3
    } action_t;

    // what the scan lane looks for
    typedef enum logic {
        SCAN_SLOT = 1'b0,
        SCAN_FIND = 1'b1
    } scan_mode_t;

    // broadcast control from the sequencer to the cell row
    typedef struct packed {
        action_t    action;
        scan_mode_t mode;
    } ctrl_t;

endpackage

// ===== sv/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: holds one word, shifts with its neighbors on insert and
// delete, and carries one stage of the scan lane that finds a slot or a match
// ----------------------------------------------------------------------------
module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int SW         = 6,
    parameter int CW         = 7,
    parameter int WORD_WIDTH = 64
) (
    input  logic                  aclk,
    input  ctrl_t                 ctrl_i,
    input  logic [SW-1:0]         slot_i,
    input  logic [CW-1:0]         count_i,
    input  logic [WORD_WIDTH-1:0] word_i,
    input  logic [WORD_WIDTH-1:0] left_i,
    input  logic [WORD_WIDTH-1:0] right_i,
    output logic [WORD_WIDTH-1:0] entry_o,
    input  logic                  scan_hit_i,
    input  logic [WORD_WIDTH-1:0] scan_data_i,
    input  logic [SW-1:0]         scan_idx_i,
    output logic                  scan_hit_o,
    output logic [WORD_WIDTH-1:0] scan_data_o,
    output logic [SW-1:0]         scan_idx_o
);

    localparam logic [SW-1:0] MY_SLOT = SW'(IDX);
    localparam logic [CW-1:0] MY_POS  = CW'(IDX);
    localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

    logic [WORD_WIDTH-1:0] entry_reg, entry_next;
    logic                  hit_reg, hit_next;
    logic [WORD_WIDTH-1:0] sdata_reg, sdata_next;
    logic [SW-1:0]         sidx_reg, sidx_next;
    logic                  match;

    // entry update for the broadcast action
    always_comb begin
        entry_next = entry_reg;
        case (ctrl_i.action)
            ACT_INSERT: begin
                if (MY_SLOT == slot_i) begin
                    entry_next = word_i;
                end else if (MY_SLOT > slot_i && MY_POS <= count_i) begin
                    entry_next = left_i;
                end
            end
            ACT_DELETE: begin
                if (MY_SLOT >= slot_i && MY_NEXT < count_i) begin
                    entry_next = right_i;
                end
            end
            ACT_WRITE: begin
                if (MY_SLOT == slot_i) begin
                    entry_next = word_i;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    // scan stage: first hit upstream wins, else this slot may claim it
    always_comb begin
        if (ctrl_i.mode == SCAN_SLOT) begin
            match = (MY_SLOT == slot_i);
        end else begin
            match = (MY_POS < count_i) && (entry_reg == word_i);
        end
        if (scan_hit_i) begin
            hit_next   = 1'b1;
            sdata_next = scan_data_i;
            sidx_next  = scan_idx_i;
        end else if (match) begin
            hit_next   = 1'b1;
            sdata_next = entry_reg;
            sidx_next  = MY_SLOT;
        end else begin
            hit_next   = 1'b0;
            sdata_next = '0;
            sidx_next  = '0;
        end
    end

    // storage and scan stage registers
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
        sdata_reg <= sdata_next;
        sidx_reg  <= sidx_next;
    end

    assign entry_o     = entry_reg;
    assign scan_hit_o  = hit_reg;
    assign scan_data_o = sdata_reg;
    assign scan_idx_o  = sidx_reg;

endmodule

// ===== sv/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of up to CAPACITY words kept in a row of cells, with push,
// pop, insert, delete, swap, read, first-match find and clear commands
// ----------------------------------------------------------------------------
//  channel  dir  fields (tdata low bit up)                       tuser
//  s_       in   position[7:0], item[71:8]                       opcode
//  m_       out  result_data[63:0], found_index[69:64],          status
//                element_count[76:70], empty_flag[77], full_flag[78]
//
//  push, insert, clear and every error: the accepted beat passes through
//  the resolve and apply states, and the result is registered in apply
//  pop, delete, swap, read, find: resolve, then a scan over the whole row,
//  then apply; the scan lane walks through the cell row one cell per cycle
//  one command at a time; s_tready is high while the sequencer is idle
//  a finished result waits in the output register while the next command
//  is taken; apply holds off while that register is still full
//  aresetn empties the list; the cell storage itself is not cleared
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int WORD_WIDTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position, item
    input  logic [OP_W-1:0]      s_tuser,   // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // result_data, found_index,
                                            // element_count, empty_flag,
                                            // full_flag, zero pad
    output logic [STAT_W-1:0]    m_tuser    // status
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > POS_W) ? CW : POS_W) + 2;
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [SW-1:0] SCAN_END = SW'(CAPACITY - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESOLVE,
        S_SCAN,
        S_APPLY
    } state_t;

    state_t                   state_reg;
    opcode_t                  op_reg;
    logic signed [POS_W-1:0]  pos_reg;
    logic [WORD_WIDTH-1:0]    word_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            cnt_new_reg;
    logic [SW-1:0]            slot_reg;
    action_t                  act_reg;
    scan_mode_t               mode_reg;
    status_t                  status_reg;
    logic [SW-1:0]            scan_cnt_reg;
    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic [STAT_W-1:0]        m_tuser_reg;

    // resolve results
    logic signed [EW-1:0]     pos_s, cnt_s, sum_s;
    logic                     in_range, at_end, is_full, is_empty;
    logic [CW-1:0]            cnt_p1, cnt_m1;
    status_t                  r_status;
    action_t                  r_act;
    scan_mode_t               r_mode;
    logic                     r_scan;
    logic [SW-1:0]            r_slot;
    logic [CW-1:0]            r_count;

    // apply results
    logic                     out_free, apply_fire, returns_data;
    ctrl_t                    ctrl;
    logic [DATA_W-1:0]        a_data;
    logic [FIDX_W-1:0]        a_found;
    status_t                  a_status;

    // cell row and scan lane
    logic [WORD_WIDTH-1:0]    cell_entry [CAPACITY];
    logic                     scan_hit   [CAPACITY+1];
    logic [WORD_WIDTH-1:0]    scan_data  [CAPACITY+1];
    logic [SW-1:0]            scan_idx   [CAPACITY+1];

    // position arithmetic against the current count
    always_comb begin
        pos_s    = EW'(pos_reg);
        cnt_s    = signed'({{(EW-CW){1'b0}}, count_reg});
        sum_s    = pos_reg[POS_W-1] ? (cnt_s + pos_s) : pos_s;
        in_range = !sum_s[EW-1] && (sum_s < cnt_s);
        at_end   = !pos_reg[POS_W-1] && (sum_s == cnt_s);
        is_full  = (count_reg == CAP_CNT);
        is_empty = (count_reg == '0);
        cnt_p1   = count_reg + 1'b1;
        cnt_m1   = count_reg - 1'b1;
    end

    // command decode: status, cell action and whether a scan is needed
    always_comb begin
        r_status = ST_OK;
        r_act    = ACT_NONE;
        r_mode   = SCAN_SLOT;
        r_scan   = 1'b0;
        r_slot   = sum_s[SW-1:0];
        r_count  = count_reg;
        case (op_reg)
            OP_PUSH: begin
                if (is_full) begin
                    r_status = ST_FULL;
                end else begin
                    r_act   = ACT_INSERT;
                    r_slot  = count_reg[SW-1:0];
                    r_count = cnt_p1;
                end
            end
            OP_POP: begin
                if (is_empty) begin
                    r_status = ST_EMPTY;
                end else begin
                    r_scan  = 1'b1;
                    r_slot  = cnt_m1[SW-1:0];
                    r_count = cnt_m1;
                end
            end
            OP_INSERT: begin
                if (is_full) begin
                    r_status = ST_FULL;
                end else if (!(in_range || at_end)) begin
                    r_status = ST_BADIDX;
                end else begin
                    r_act   = ACT_INSERT;
                    r_count = cnt_p1;
                end
            end
            OP_DELETE: begin
                if (is_empty) begin
                    r_status = ST_EMPTY;
                end else if (!in_range) begin
                    r_status = ST_BADIDX;
                end else begin
                    r_scan  = 1'b1;
                    r_act   = ACT_DELETE;
                    r_count = cnt_m1;
                end
            end
            OP_SWAP: begin
                if (is_empty) begin
                    r_status = ST_EMPTY;
                end else if (!in_range) begin
                    r_status = ST_BADIDX;
                end else begin
                    r_scan = 1'b1;
                    r_act  = ACT_WRITE;
                end
            end
            OP_READ: begin
                if (is_empty) begin
                    r_status = ST_EMPTY;
                end else if (!in_range) begin
                    r_status = ST_BADIDX;
                end else begin
                    r_scan = 1'b1;
                end
            end
            OP_FIND: begin
                r_scan = 1'b1;
                r_mode = SCAN_FIND;
            end
            OP_CLEAR: begin
                r_count = '0;
            end
            default: begin
                r_status = ST_OK;
            end
        endcase
    end

    // result forming in the apply cycle
    always_comb begin
        out_free     = !m_tvalid_reg || m_tready;
        apply_fire   = (state_reg == S_APPLY) && out_free;
        ctrl.action  = apply_fire ? act_reg : ACT_NONE;
        ctrl.mode    = mode_reg;
        returns_data = (status_reg == ST_OK) &&
                       (op_reg == OP_POP || op_reg == OP_DELETE ||
                        op_reg == OP_SWAP || op_reg == OP_READ);
        a_data       = returns_data ? DATA_W'(scan_data[CAPACITY]) : '0;
        a_found      = '0;
        a_status     = status_reg;
        if (op_reg == OP_FIND) begin
            a_status = scan_hit[CAPACITY] ? ST_OK : ST_NOTFOUND;
            a_found  = scan_hit[CAPACITY] ? FIDX_W'(scan_idx[CAPACITY]) : '0;
        end
    end

    // scan lane enters the row with no hit
    assign scan_hit[0]  = 1'b0;
    assign scan_data[0] = '0;
    assign scan_idx[0]  = '0;

    // row of cells, each linked to its neighbors; the head's left input is the command word
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_WIDTH-1:0] left_w, right_w;
        if (i == 0) begin : g_head
            assign left_w = word_reg;
        end else begin : g_left
            assign left_w = cell_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign right_w = '0;
        end else begin : g_right
            assign right_w = cell_entry[i+1];
        end
        ple_cell #(
            .IDX        (i),
            .SW         (SW),
            .CW         (CW),
            .WORD_WIDTH (WORD_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .ctrl_i      (ctrl),
            .slot_i      (slot_reg),
            .count_i     (count_reg),
            .word_i      (word_reg),
            .left_i      (left_w),
            .right_i     (right_w),
            .entry_o     (cell_entry[i]),
            .scan_hit_i  (scan_hit[i]),
            .scan_data_i (scan_data[i]),
            .scan_idx_i  (scan_idx[i]),
            .scan_hit_o  (scan_hit[i+1]),
            .scan_data_o (scan_data[i+1]),
            .scan_idx_o  (scan_idx[i+1])
        );
    end

    // sequencer, count and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            scan_cnt_reg <= '0;
        end else begin
            // output beat valid: set by apply, cleared once taken
            if (apply_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= opcode_t'(s_tuser);
                        pos_reg   <= s_tdata[POS_W-1:0];
                        word_reg  <= s_tdata[POS_W +: WORD_WIDTH];
                        state_reg <= S_RESOLVE;
                    end
                end
                S_RESOLVE: begin
                    status_reg   <= r_status;
                    act_reg      <= r_act;
                    mode_reg     <= r_mode;
                    slot_reg     <= r_slot;
                    cnt_new_reg  <= r_count;
                    scan_cnt_reg <= '0;
                    state_reg    <= r_scan ? S_SCAN : S_APPLY;
                end
                S_SCAN: begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == SCAN_END) begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (out_free) begin
                        count_reg    <= cnt_new_reg;
                        m_tdata_reg  <= {1'b0,
                                         cnt_new_reg == CAP_CNT,
                                         cnt_new_reg == '0,
                                         ECNT_W'(cnt_new_reg),
                                         a_found,
                                         a_data};
                        m_tuser_reg  <= a_status;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `PLE_ASSERT(a_count_bound, count_reg <= CAP_CNT, "count above capacity")
    `PLE_ASSERT_NEXT(a_accept_resolve, s_tvalid && s_tready, state_reg == S_RESOLVE, "no resolve")
    `PLE_ASSERT_NEXT(a_apply_done, apply_fire, (state_reg == S_IDLE) && m_tvalid_reg, "no result")
    `PLE_ASSERT_NEXT(a_count_hold, !apply_fire, $stable(count_reg), "count moved outside apply")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the positional list engine: commands are driven on
// the s_ stream with random gaps, results are taken on the m_ stream with
// random back-pressure, and each result beat is compared field by field with
// a software copy of the list kept in a small tracker class
// ----------------------------------------------------------------------------
module tb_top;
    import ple_pkg::*;

    localparam int CAP = 64;

    // expected content of one result beat
    typedef struct {
        logic [DATA_W-1:0] data;
        logic [FIDX_W-1:0] found;
        status_t           status;
        logic [ECNT_W-1:0] count;
        logic              empty;
        logic              full;
    } list_result_t;

    // shadow list, the results it predicts and the mismatch count
    class list_tracker;
        logic [DATA_W-1:0] words [CAP];
        int                count;
        list_result_t      expected_q[$];
        int                errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 100) $display("mismatch: %s", msg);
        endfunction

        // map a signed position to a slot; false when out of range
        function bit locate(int pos, bit allow_end, output int slot);
            int s;
            s    = (pos < 0) ? count + pos : pos;
            slot = s;
            if (s < 0) return 1'b0;
            return (s < count) || (allow_end && pos >= 0 && s == count);
        endfunction

        // apply one accepted command and queue the result it causes
        function void note_command(opcode_t op, logic signed [POS_W-1:0] pos,
                                   logic [ITEM_W-1:0] word);
            list_result_t r;
            int           slot;
            int           p;
            int           i;
            p        = int'(pos);
            r.data   = '0;
            r.found  = '0;
            r.status = ST_OK;
            case (op)
                OP_PUSH: begin
                    if (count >= CAP) r.status = ST_FULL;
                    else begin
                        words[count] = word;
                        count++;
                    end
                end
                OP_POP: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else begin
                        count--;
                        r.data = words[count];
                    end
                end
                OP_INSERT: begin
                    if (count >= CAP) r.status = ST_FULL;
                    else if (!locate(p, 1'b1, slot)) r.status = ST_BADIDX;
                    else begin
                        for (i = count; i > slot; i--) words[i] = words[i-1];
                        words[slot] = word;
                        count++;
                    end
                end
                OP_DELETE: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else if (!locate(p, 1'b0, slot)) r.status = ST_BADIDX;
                    else begin
                        r.data = words[slot];
                        for (i = slot; i + 1 < count; i++) words[i] = words[i+1];
                        count--;
                    end
                end
                OP_SWAP: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else if (!locate(p, 1'b0, slot)) r.status = ST_BADIDX;
                    else begin
                        r.data      = words[slot];
                        words[slot] = word;
                    end
                end
                OP_READ: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else if (!locate(p, 1'b0, slot)) r.status = ST_BADIDX;
                    else r.data = words[slot];
                end
                OP_FIND: begin
                    r.status = ST_NOTFOUND;
                    for (i = 0; i < count; i++) begin
                        if (words[i] == word) begin
                            r.found  = FIDX_W'(i);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
                default: count = 0;
            endcase
            r.count = ECNT_W'(count);
            r.empty = (count == 0);
            r.full  = (count == CAP);
            expected_q.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic [M_TDATA_W-1:0] td, logic [STAT_W-1:0] tu);
            list_result_t e;
            if (expected_q.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            e = expected_q.pop_front();
            compare("result_data", td[63:0], e.data);
            compare("found_index", 64'(td[69:64]), 64'(e.found));
            compare("element_count", 64'(td[76:70]), 64'(e.count));
            compare("empty_flag", 64'(td[77]), 64'(e.empty));
            compare("full_flag", 64'(td[78]), 64'(e.full));
            compare("status", 64'(tu), 64'(e.status));
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // position, item
    logic [OP_W-1:0]      s_tuser  = '0;   // opcode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // result_data, found_index,
                                           // element_count, empty_flag,
                                           // full_flag, zero pad
    logic [STAT_W-1:0]    m_tuser;         // status

    bit          quiet = 1'b0;
    list_tracker tracker = new();

    // words that recur so that find sees duplicates and extremes
    logic [63:0] word_pool [8] = '{
        64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h8000_0000_0000_0000,
        64'h5A5A_5A5A_5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5,
        64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000
    };

    positional_list_engine #(
        .CAPACITY   (CAP),
        .WORD_WIDTH (DATA_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // result side: random back-pressure bursts, none in the quiet tail
    initial begin
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // every accepted result beat goes to the tracker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
    end

    // drive one command beat, with an optional idle burst in front
    task automatic send_command(opcode_t op, logic signed [POS_W-1:0] pos,
                                logic [ITEM_W-1:0] word);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {word, pos};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        tracker.note_command(op, pos, word);
    endtask

    // hold the sender until every outstanding result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.expected_q.size() != 0) @(posedge aclk);
    endtask

    // random commands in episodes that grow, shrink or churn the list
    task automatic run_random(int total);
        int done;
        int mode;
        int span;
        int r;
        int k;
        opcode_t op;
        logic signed [POS_W-1:0] pos;
        logic [ITEM_W-1:0] word;
        done = 0;
        while (done < total) begin
            mode = $urandom_range(0, 2);
            span = (mode == 0) ? $urandom_range(40, 120) : $urandom_range(10, 80);
            for (k = 0; k < span && done < total; k++) begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: op = (r < 45) ? OP_PUSH : (r < 85) ? OP_INSERT
                                               : opcode_t'($urandom_range(1, 7));
                    1: op = (r < 35) ? OP_POP : (r < 70) ? OP_DELETE
                                              : opcode_t'($urandom_range(0, 7));
                    default: op = (r < 3) ? OP_CLEAR : opcode_t'($urandom_range(0, 6));
                endcase
                // data word: recurring value, stored word or fresh random
                r = $urandom_range(0, 9);
                if (r < 3) word = word_pool[3'($urandom_range(0, 7))];
                else if (r < 6 && tracker.count > 0)
                    word = tracker.words[$urandom_range(0, tracker.count - 1)];
                else word = {$urandom, $urandom};
                // position: mostly legal, else anywhere in the 8-bit range
                r = $urandom_range(0, 9);
                if (r < 7 && tracker.count > 0) begin
                    if ($urandom_range(0, 1))
                        pos = POS_W'($urandom_range(0, tracker.count -
                                                    ((op == OP_INSERT) ? 0 : 1)));
                    else
                        pos = POS_W'(-$urandom_range(1, tracker.count));
                end else if (r < 9) begin
                    pos = POS_W'($urandom_range(0, 128) - 64);
                end else begin
                    pos = POS_W'($urandom_range(0, 255));
                end
                send_command(op, pos, word);
                done++;
            end
        end
    endtask

    // main sequence
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list corner cases
        send_command(OP_POP,    8'sd0,    64'h0);
        send_command(OP_DELETE, 8'sd0,    64'h0);
        send_command(OP_SWAP,   -8'sd1,   64'h1234);
        send_command(OP_READ,   8'sd127,  64'h0);
        send_command(OP_FIND,   8'sd0,    64'h0);
        send_command(OP_INSERT, 8'sd1,    64'h77);
        send_command(OP_INSERT, -8'sd1,   64'h77);
        // append to empty, then delete of the sole word
        send_command(OP_INSERT, 8'sd0,    64'hFFFF_FFFF_FFFF_FFFF);
        send_command(OP_DELETE, -8'sd1,   64'h0);
        // build a short list and probe positions
        send_command(OP_PUSH,   8'sd0,    64'h0);
        send_command(OP_PUSH,   8'sd0,    64'hFFFF_FFFF_FFFF_FFFF);
        send_command(OP_INSERT, 8'sd2,    64'h5A5A_5A5A_5A5A_5A5A);
        send_command(OP_INSERT, -8'sd64,  64'h1);
        send_command(OP_INSERT, -8'sd3,   64'hA5A5_A5A5_A5A5_A5A5);
        send_command(OP_READ,   8'sd64,   64'h0);
        send_command(OP_READ,   -8'sd128, 64'h0);
        send_command(OP_SWAP,   8'sd0,    64'h8000_0000_0000_0000);
        send_command(OP_FIND,   8'sd0,    64'hFFFF_FFFF_FFFF_FFFF);
        send_command(OP_FIND,   8'sd0,    64'hA5A5_A5A5_A5A5_A5A5);
        send_command(OP_PUSH,   8'sd0,    64'h0);
        send_command(OP_FIND,   8'sd0,    64'h0);
        send_command(OP_DELETE, 8'sd127,  64'h0);
        send_command(OP_POP,    8'sd0,    64'h0);
        send_command(OP_READ,   -8'sd1,   64'h0);
        send_command(OP_CLEAR,  8'sd0,    64'h0);
        send_command(OP_POP,    8'sd0,    64'h0);
        wait_idle();

        run_random(325);
        wait_idle();
        run_random(325);
        quiet = 1'b1;
        run_random(100);

        // drain and let any stray beat show up
        wait_idle();
        repeat (CAP + 8) @(posedge aclk);
        if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
